>>> rtl/sbp_pkg.sv
// sbp_pkg: shared types, codes and helpers of the symbol bit packer/unpacker
// no dependencies; imported by every module of the block
package sbp_pkg;

  // widths that follow from the fixed 8-bit byte and 1..8 bit symbols
  localparam int unsigned ByteW  = 8;
  localparam int unsigned WidthW = 4;   // holds 0..15, symbol widths 1..8
  localparam int unsigned HeldW  = 3;   // held bit count 0..7
  localparam int unsigned AccW   = 15;  // up to 7 held bits plus 8 new ones

  localparam logic [WidthW-1:0] SymBitsReset = 4'd2;
  localparam logic [WidthW-1:0] FullByte     = 4'd8;

  // opcodes
  localparam logic OpPack   = 1'b0;
  localparam logic OpUnpack = 1'b1;

  // result kinds
  localparam logic KindByte = 1'b0;
  localparam logic KindSym  = 1'b1;

  // one classified item: a bit run and how to slice it into result beats
  typedef struct packed {
    logic [AccW-1:0]   acc;         // bits, lsb first
    logic [WidthW-1:0] width;       // bits per beat
    logic [WidthW-1:0] last_width;  // bits in the final beat
    logic [WidthW-1:0] count;       // number of beats, 1..8
    logic              kind;
  } sbp_job_t;

  // mask of the n low bits, n from 0 to 15
  function automatic logic [ByteW-1:0] low_mask(logic [WidthW-1:0] n);
    logic [ByteW-1:0] m;
    if (n >= FullByte) begin
      m = '1;
    end else begin
      m = (ByteW'(1) << n) - ByteW'(1);
    end
    return m;
  endfunction

endpackage

>>> rtl/sbp_cfg_if.sv
// sbp_cfg_if: configuration write channel of the bit packer/unpacker
// depends on sbp_pkg for the register width
interface sbp_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [sbp_pkg::WidthW-1:0]       symbol_bits;

  modport source (output valid, output symbol_bits, input ready);
  modport sink   (input valid, input symbol_bits, output ready);
endinterface

>>> rtl/sbp_in_if.sv
// sbp_in_if: input item channel of the bit packer/unpacker
// depends on sbp_pkg for field widths
interface sbp_in_if;
  logic                       valid;
  logic                       ready;
  logic                       opcode;
  logic [sbp_pkg::ByteW-1:0]  in_value;
  logic                       final_byte;

  modport source (output valid, output opcode, output in_value, output final_byte,
                  input ready);
  modport sink   (input valid, input opcode, input in_value, input final_byte,
                  output ready);
endinterface

>>> rtl/sbp_out_if.sv
// sbp_out_if: result channel of the bit packer/unpacker
// depends on sbp_pkg for field widths
interface sbp_out_if;
  logic                       valid;
  logic                       ready;
  logic [sbp_pkg::ByteW-1:0]  out_value;
  logic                       out_kind;
  logic                       run_end;

  modport source (output valid, output out_value, output out_kind, output run_end,
                  input ready);
  modport sink   (input valid, input out_value, input out_kind, input run_end,
                  output ready);
endinterface

>>> rtl/sbp_front.sv
// sbp_front: config register, held bit state and item classification
// depends on sbp_pkg, sbp_cfg_if and sbp_in_if
module sbp_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  sbp_cfg_if.sink           cfg_i,
  sbp_in_if.sink            in_i,
  output sbp_pkg::sbp_job_t job_o,
  output logic              job_valid_o,
  input  logic              job_ready_i
);
  import sbp_pkg::*;

  // number of whole symbols of width w in total bits, capped at eight
  function automatic logic [WidthW-1:0] sym_count(logic [WidthW-1:0] total,
                                                  logic [WidthW-1:0] w);
    logic [WidthW-1:0] q;
    q = '0;
    for (int k = 1; k <= 8; k++) begin
      if ((8'(k) * {4'd0, w}) <= {4'd0, total}) begin
        q = WidthW'(k);
      end
    end
    return q;
  endfunction

  logic [WidthW-1:0] sym_bits_q;
  logic [ByteW-1:0]  held_q, held_d;
  logic [HeldW-1:0]  hcnt_q, hcnt_d;

  logic              accept;
  logic              emit;
  logic [WidthW-1:0] w;
  logic [ByteW-1:0]  sym;
  logic [AccW-1:0]   acc_pk, acc_up, rest;
  logic [WidthW-1:0] tot_pk, tot_up, nsym, used, rem;
  logic [7:0]        prod;
  logic              tail;

  assign cfg_i.ready = 1'b1;
  assign in_i.ready  = job_ready_i;
  assign accept      = in_i.valid && in_i.ready;
  assign job_valid_o = accept && emit;

  // out-of-range widths clamp to 1..8
  always_comb begin
    if (sym_bits_q == '0) begin
      w = WidthW'(1);
    end else if (sym_bits_q > FullByte) begin
      w = FullByte;
    end else begin
      w = sym_bits_q;
    end
  end

  always_comb begin
    sym    = in_i.in_value & low_mask(w);
    acc_pk = {7'd0, held_q} | ({7'd0, sym} << hcnt_q);
    tot_pk = {1'b0, hcnt_q} + w;
    acc_up = {7'd0, held_q} | ({7'd0, in_i.in_value} << hcnt_q);
    tot_up = {1'b0, hcnt_q} + FullByte;
    nsym   = sym_count(tot_up, w);
    prod   = {4'd0, nsym} * {4'd0, w};
    used   = prod[WidthW-1:0];
    rem    = tot_up - used;
    rest   = acc_up >> used;
    tail   = in_i.final_byte && (rem != '0) && (nsym != FullByte);
  end

  always_comb begin
    job_o.acc        = acc_pk;
    job_o.width      = FullByte;
    job_o.last_width = FullByte;
    job_o.count      = WidthW'(1);
    job_o.kind       = KindByte;
    emit             = 1'b0;
    held_d           = held_q;
    hcnt_d           = hcnt_q;
    unique case (in_i.opcode)
      OpPack: begin
        emit = (tot_pk >= FullByte);
        if (emit) begin
          hcnt_d = tot_pk[HeldW-1:0];
          held_d = {1'b0, acc_pk[AccW-1:ByteW]} & low_mask({1'b0, tot_pk[HeldW-1:0]});
        end else begin
          hcnt_d = tot_pk[HeldW-1:0];
          held_d = acc_pk[ByteW-1:0];
        end
      end
      OpUnpack: begin
        emit             = 1'b1;
        job_o.acc        = acc_up;
        job_o.width      = w;
        job_o.last_width = tail ? rem : w;
        job_o.count      = nsym + {3'd0, tail};
        job_o.kind       = KindSym;
        if (in_i.final_byte) begin
          hcnt_d = '0;
          held_d = '0;
        end else begin
          hcnt_d = rem[HeldW-1:0];
          held_d = rest[ByteW-1:0] & low_mask({1'b0, rem[HeldW-1:0]});
        end
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sym_bits_q <= SymBitsReset;
      held_q     <= '0;
      hcnt_q     <= '0;
    end else if (cfg_i.valid && cfg_i.ready) begin
      sym_bits_q <= cfg_i.symbol_bits;
      held_q     <= '0;
      hcnt_q     <= '0;
    end else if (accept) begin
      held_q <= held_d;
      hcnt_q <= hcnt_d;
    end
  end

endmodule

>>> rtl/sbp_queue.sv
// sbp_queue: short job queue between the front and the back
// depends on sbp_pkg for the job type
module sbp_queue #(
  parameter int unsigned Depth = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  sbp_pkg::sbp_job_t push_data_i,
  input  logic              push_valid_i,
  output logic              push_ready_o,
  output sbp_pkg::sbp_job_t pop_data_o,
  output logic              pop_valid_o,
  input  logic              pop_ready_i
);
  import sbp_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  sbp_job_t          mem_q [Depth];
  logic [PtrW-1:0]   wr_q, rd_q;
  logic [CntW-1:0]   cnt_q;
  logic              push, pop;

  assign push_ready_o = (cnt_q != CntW'(Depth));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_data_o   = mem_q[rd_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  function automatic logic [PtrW-1:0] ptr_next(logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) begin
        wr_q <= ptr_next(wr_q);
      end
      if (pop) begin
        rd_q <= ptr_next(rd_q);
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

>>> rtl/sbp_back.sv
// sbp_back: slices queued jobs into result beats, one per cycle while the output is not stalled
// depends on sbp_pkg and sbp_out_if
module sbp_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  sbp_pkg::sbp_job_t job_i,
  input  logic              job_valid_i,
  output logic              job_ready_o,
  sbp_out_if.source         out_o
);
  import sbp_pkg::*;

  logic              act_q;
  logic [AccW-1:0]   acc_q;
  logic [WidthW-1:0] w_q, lw_q, cnt_q;
  logic              kind_q;

  logic              out_valid_q;
  logic [ByteW-1:0]  out_value_q;
  logic              out_kind_q, run_end_q;

  logic              load, last, pop, take;
  logic [WidthW-1:0] beat_w;

  assign last        = (cnt_q == WidthW'(1));
  assign load        = act_q && (!out_valid_q || out_o.ready);
  assign pop         = !act_q || (load && last);
  assign take        = pop && job_valid_i;
  assign job_ready_o = pop;
  assign beat_w      = last ? lw_q : w_q;

  assign out_o.valid     = out_valid_q;
  assign out_o.out_value = out_value_q;
  assign out_o.out_kind  = out_kind_q;
  assign out_o.run_end   = run_end_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q <= 1'b0;
    end else if (take) begin
      act_q <= 1'b1;
    end else if (load && last) begin
      act_q <= 1'b0;
    end
  end

  // job payload
  always_ff @(posedge clk_i) begin
    if (take) begin
      acc_q  <= job_i.acc;
      w_q    <= job_i.width;
      lw_q   <= job_i.last_width;
      cnt_q  <= job_i.count;
      kind_q <= job_i.kind;
    end else if (load) begin
      acc_q <= acc_q >> w_q;
      cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk_i) begin
    if (load) begin
      out_value_q <= acc_q[ByteW-1:0] & low_mask(beat_w);
      out_kind_q  <= kind_q;
      run_end_q   <= last;
    end
  end

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    act_q |-> (cnt_q != '0) && (cnt_q <= FullByte))
    else $error("active job with beat count out of range");

  a_width_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    act_q |-> (w_q != '0) && (w_q <= FullByte) && (lw_q != '0) && (lw_q <= w_q))
    else $error("active job with bad slice width");

  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_o.ready && !act_q) |=> !out_valid_q)
    else $error("output register refilled with no job in hand");

endmodule

>>> rtl/symbol_bit_packer_unpacker.sv
// symbol_bit_packer_unpacker: lsb-first packer/unpacker between bytes and 1..8 bit symbols
// depends on sbp_pkg, the sbp_*_if interfaces, sbp_front, sbp_queue and sbp_back
//
//   channel  dir  beat carries                       taken when
//   cfg_i    in   symbol_bits                        cfg_i.valid && cfg_i.ready
//   in_i     in   opcode, in_value, final_byte       in_i.valid && in_i.ready
//   out_o    out  out_value, out_kind, run_end       out_o.valid && out_o.ready
//
// an input beat is taken every cycle while the job queue has room; the held
// bit state is updated in the same cycle, so the next beat never waits on it
// the back end sends one result per cycle while the output is not stalled: an item
// gives 1 to 8 results, a pack beat that completes no byte gives no job and no result
// first result of an item passes the job queue, the back end job register and the output register
// reset: symbol_bits 2, held bits empty, queue and output register empty
// a stalled output only fills the queue; input stalls once it holds QueueDepth jobs
module symbol_bit_packer_unpacker #(
  parameter int unsigned QueueDepth = 4
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  sbp_cfg_if.sink   cfg_i,
  sbp_in_if.sink    in_i,
  sbp_out_if.source out_o
);
  import sbp_pkg::*;

  // classified jobs from the front into the queue
  sbp_job_t push_job;
  logic     push_valid, push_ready;

  // queue head into the back
  sbp_job_t pop_job;
  logic     pop_valid, pop_ready;

  // front: config register, held bits, turns each beat into a job (none for a pack beat that completes no byte)
  sbp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_i),
    .in_i        (in_i),
    .job_o       (push_job),
    .job_valid_o (push_valid),
    .job_ready_i (push_ready)
  );

  // decouples the two sides so either can stall on its own
  sbp_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_data_i  (push_job),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .pop_data_o   (pop_job),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready)
  );

  // back: one result beat per cycle into the output register while out_o is not stalled
  sbp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_i       (pop_job),
    .job_valid_i (pop_valid),
    .job_ready_o (pop_ready),
    .out_o       (out_o)
  );

endmodule

>>> tb/symbol_bit_packer_unpacker_test.sv
// symbol_bit_packer_unpacker_test: self-checking bench for the lsb-first bit packer/unpacker
// drives the cfg, in and out channels of the block with bursty traffic and predicts every beat
// depends on sbp_pkg, the sbp_*_if interfaces and symbol_bit_packer_unpacker
module symbol_bit_packer_unpacker_test;
  import sbp_pkg::*;

  typedef struct packed {
    logic             opcode;
    logic [ByteW-1:0] in_value;
    logic             final_byte;
  } sbp_item_t;

  typedef struct packed {
    logic [ByteW-1:0] out_value;
    logic             out_kind;
    logic             run_end;
  } sbp_beat_t;

  localparam int unsigned WatchdogLimit  = 2000;
  localparam int unsigned LongHoldCycles = 120;
  localparam int unsigned SettleCycles   = 8;
  localparam int unsigned ReportLimit    = 50;
  localparam int unsigned PhaseItems     = 30;

  logic clk_i;
  logic rst_ni;

  sbp_cfg_if cfg_if ();
  sbp_in_if  in_if ();
  sbp_out_if out_if ();

  symbol_bit_packer_unpacker dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_if),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  sbp_item_t pending_items[$];
  sbp_beat_t expected_beats[$];

  // mirror of the block's bit stream state
  logic [WidthW-1:0] sym_bits_m;
  logic [ByteW-1:0]  held_bits_m;
  logic [HeldW-1:0]  held_count_m;

  int unsigned mismatch_count;
  int unsigned idle_cycles;
  int unsigned burst_left;
  int unsigned gap_left;
  int unsigned hold_left;
  logic [31:0] stall_word;
  logic [4:0]  stall_phase;
  bit          in_beat_seen;
  bit          steady;
  bit          long_hold_req;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic logic [15:0] ones_below(input int unsigned n);
    return (16'd1 << n) - 16'd1;
  endfunction

  // out-of-range widths fold onto 1 and 8
  function automatic int unsigned symbol_width(input logic [WidthW-1:0] bits);
    if (bits == '0) return 1;
    if (bits > FullByte) return 8;
    return int'(bits);
  endfunction

  // appends one symbol or byte to the held bits and queues the beats it completes
  task automatic advance_bit_stream(input sbp_item_t item);
    int unsigned w;
    int unsigned total;
    logic [15:0] acc;
    sbp_beat_t   run[$];
    sbp_beat_t   beat;
    w     = symbol_width(sym_bits_m);
    total = held_count_m;
    acc   = 16'(held_bits_m) & ones_below(total);
    beat  = '0;
    if (item.opcode == OpPack) begin
      acc   |= (16'(item.in_value) & ones_below(w)) << total;
      total += w;
      if (total >= ByteW) begin
        beat.out_value = acc[7:0];
        beat.out_kind  = KindByte;
        run.push_back(beat);
        acc   >>= ByteW;
        total -= ByteW;
      end
    end else begin
      acc   |= 16'(item.in_value) << total;
      total += ByteW;
      // at most eight symbols per byte, the rest stays held
      while (total >= w && run.size() < 8) begin
        beat.out_value = 8'(acc & ones_below(w));
        beat.out_kind  = KindSym;
        run.push_back(beat);
        acc   >>= w;
        total -= w;
      end
      if (item.final_byte) begin
        // leftover bits go out as one short symbol unless eight symbols were made, then the stream restarts
        if (total > 0 && run.size() < 8) begin
          beat.out_value = 8'(acc & ones_below(total));
          beat.out_kind  = KindSym;
          run.push_back(beat);
        end
        acc   = '0;
        total = 0;
      end
    end
    held_count_m = HeldW'(total);
    held_bits_m  = 8'(acc & ones_below(total));
    foreach (run[i]) begin
      beat         = run[i];
      beat.run_end = (i == run.size() - 1);
      expected_beats.push_back(beat);
    end
  endtask

  task automatic report_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= ReportLimit) $display("%0t beat check failed: %s", $time, what);
  endtask

  // predictor, checker and watchdog, all on the rising edge
  always @(posedge clk_i) begin : monitor
    sbp_beat_t got;
    sbp_beat_t want;
    bit        cfg_beat;
    bit        out_beat;
    if (!rst_ni) begin
      sym_bits_m   = SymBitsReset;
      held_bits_m  = '0;
      held_count_m = '0;
      in_beat_seen = 1'b0;
      idle_cycles  = 0;
    end else begin
      cfg_beat     = cfg_if.valid && cfg_if.ready;
      in_beat_seen = in_if.valid && in_if.ready;
      out_beat     = out_if.valid && out_if.ready;
      if (cfg_beat) begin
        sym_bits_m   = cfg_if.symbol_bits;
        held_bits_m  = '0;
        held_count_m = '0;
      end
      if (in_beat_seen) begin
        advance_bit_stream('{opcode: in_if.opcode, in_value: in_if.in_value,
                             final_byte: in_if.final_byte});
      end
      if (out_beat) begin
        got = '{out_value: out_if.out_value, out_kind: out_if.out_kind,
                run_end: out_if.run_end};
        if (expected_beats.size() == 0) begin
          report_mismatch($sformatf("beat with nothing expected: value %02h kind %0b end %0b",
                                    got.out_value, got.out_kind, got.run_end));
        end else begin
          want = expected_beats.pop_front();
          if (got.out_value !== want.out_value)
            report_mismatch($sformatf("out_value %02h, wanted %02h",
                                      got.out_value, want.out_value));
          if (got.out_kind !== want.out_kind)
            report_mismatch($sformatf("out_kind %0b, wanted %0b", got.out_kind, want.out_kind));
          if (got.run_end !== want.run_end)
            report_mismatch($sformatf("run_end %0b, wanted %0b", got.run_end, want.run_end));
        end
      end
      if (cfg_beat || in_beat_seen || out_beat) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WatchdogLimit) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  // sender: bursts of items with random gaps, a held item stays until taken
  always @(negedge clk_i) begin : sender
    sbp_item_t item;
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
    end else if (!in_if.valid || in_beat_seen) begin
      if (!steady && gap_left > 0) begin
        gap_left--;
        in_if.valid <= 1'b0;
      end else if (pending_items.size() == 0) begin
        in_if.valid <= 1'b0;
      end else begin
        item = pending_items.pop_front();
        in_if.opcode     <= item.opcode;
        in_if.in_value   <= item.in_value;
        in_if.final_byte <= item.final_byte;
        in_if.valid      <= 1'b1;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 16);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
        end else begin
          burst_left--;
        end
      end
    end
  end

  // receiver: random stall words of changing density, plus one long hold-off on request
  always @(negedge clk_i) begin : receiver
    if (long_hold_req) begin
      hold_left     = LongHoldCycles;
      long_hold_req = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_if.ready <= 1'b0;
    end else if (steady || !rst_ni) begin
      out_if.ready <= 1'b1;
    end else begin
      if (stall_phase == '0)
        stall_word = $urandom_range(0, 1) ? $urandom : ($urandom & $urandom & $urandom);
      out_if.ready <= !stall_word[stall_phase];
      stall_phase++;
    end
  end

  task automatic queue_item(input logic op, input logic [ByteW-1:0] value, input logic fin);
    pending_items.push_back('{opcode: op, in_value: value, final_byte: fin});
  endtask

  // block idle: everything sent, every beat back, then a settle wait for beatless items
  task automatic wait_for_idle();
    do @(posedge clk_i);
    while (pending_items.size() != 0 || in_if.valid || expected_beats.size() != 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_symbol_bits(input logic [WidthW-1:0] bits);
    @(negedge clk_i);
    cfg_if.symbol_bits <= bits;
    cfg_if.valid       <= 1'b1;
    do @(posedge clk_i);
    while (!(cfg_if.valid && cfg_if.ready));
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  // mostly well-formed pack runs and unpack buffers, some loose noise items
  task automatic queue_random_phase(input int unsigned n_items);
    int unsigned made;
    int unsigned run_len;
    int unsigned pick;
    made = 0;
    while (made < n_items) begin
      pick = $urandom_range(0, 9);
      if (pick < 4) begin
        run_len = $urandom_range(1, 16);
        repeat (run_len) queue_item(OpPack, 8'($urandom), 1'($urandom));
      end else if (pick < 9) begin
        run_len = $urandom_range(1, 6);
        for (int i = 1; i <= run_len; i++) queue_item(OpUnpack, 8'($urandom), i == run_len);
      end else begin
        run_len = $urandom_range(1, 4);
        repeat (run_len) queue_item(1'($urandom), 8'($urandom), 1'($urandom));
      end
      made += run_len;
    end
  endtask

  initial begin : stimulus
    logic [WidthW-1:0] phase_bits[12];
    phase_bits = '{4'd1, 4'd8, 4'd0, 4'd15, 4'd3, 4'd5, 4'd7, 4'd4, 4'd6, 4'd2, 4'd12, 4'd0};
    phase_bits[11] = 4'($urandom);
    mismatch_count     = 0;
    burst_left         = 0;
    gap_left           = 0;
    hold_left          = 0;
    stall_word         = '0;
    stall_phase        = '0;
    steady             = 1'b0;
    long_hold_req      = 1'b0;
    rst_ni             = 1'b0;
    cfg_if.valid       = 1'b0;
    cfg_if.symbol_bits = '0;
    in_if.valid        = 1'b0;
    in_if.opcode       = OpPack;
    in_if.in_value     = '0;
    in_if.final_byte   = 1'b0;
    out_if.ready       = 1'b0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // reset width of two: masking, a byte completing, final ignored when packing
    queue_item(OpPack, 8'hFF, 1'b1);
    queue_item(OpPack, 8'h00, 1'b0);
    queue_item(OpPack, 8'h02, 1'b0);
    queue_item(OpPack, 8'h01, 1'b0);
    queue_item(OpPack, 8'hFE, 1'b0);
    // unpacking carries on from the held pack bits
    queue_item(OpUnpack, 8'h00, 1'b0);
    queue_item(OpUnpack, 8'hFF, 1'b1);
    queue_item(OpPack, 8'h03, 1'b0);
    queue_item(OpUnpack, 8'h81, 1'b1);
    wait_for_idle();
    // width three: short trailing symbol on a final byte, then a write clears held bits
    write_symbol_bits(4'd3);
    queue_item(OpPack, 8'h07, 1'b0);
    queue_item(OpUnpack, 8'hFF, 1'b1);
    queue_item(OpUnpack, 8'h80, 1'b1);
    queue_item(OpPack, 8'h05, 1'b0);
    wait_for_idle();
    // width one with seven bits held: a byte gives only eight symbols, the rest is dropped
    write_symbol_bits(4'd1);
    repeat (7) queue_item(OpPack, 8'hFF, 1'b0);
    queue_item(OpUnpack, 8'h00, 1'b1);
    queue_item(OpUnpack, 8'hFF, 1'b0);
    wait_for_idle();
    // widths out of range
    write_symbol_bits(4'd0);
    queue_item(OpUnpack, 8'h81, 1'b1);
    wait_for_idle();
    write_symbol_bits(4'd15);
    queue_item(OpUnpack, 8'hC3, 1'b0);
    queue_item(OpPack, 8'hFF, 1'b0);
    wait_for_idle();
    write_symbol_bits(4'd9);
    queue_item(OpPack, 8'h80, 1'b1);
    wait_for_idle();

    foreach (phase_bits[p]) begin
      write_symbol_bits(phase_bits[p]);
      // first and seventh phases run flat out; the first also gets a long output hold-off so the input backs up
      steady = (p == 0 || p == 6);
      queue_random_phase(PhaseItems);
      if (p == 0) begin
        @(posedge clk_i);
        long_hold_req = 1'b1;
      end
      wait_for_idle();
    end

    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
